FILE: design/pooling_2d_max_avg_defines.svh
// Assertion macros shared by the pooling block
`ifndef POOLING_2D_MAX_AVG_DEFINES_SVH
`define POOLING_2D_MAX_AVG_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PL2D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PL2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pl2d_pkg.sv
// Types, constants and helper functions of the pooling block
package pl2d_pkg;

   localparam int PIX_W      = 16;
   localparam int SIDE_W     = 7;
   localparam int WIN_W      = 4;
   localparam int POS_W      = 6;
   localparam int MAX_SIDE   = 64;
   localparam int MAX_WINDOW = 8;
   localparam int ROWSEL_W   = $clog2(MAX_WINDOW);
   localparam int STORE_DEPTH = MAX_WINDOW * MAX_SIDE;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int ACC_W      = PIX_W + 2 * ROWSEL_W;
   localparam int SQ_W       = 2 * ROWSEL_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int DIV_CNT_W  = 3;
   localparam int AVG_CNT_W  = $clog2(ACC_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_SIDE  = 2'd0,
      CSR_WINDOW_SIZE = 2'd1,
      CSR_STRIDE_STEP = 2'd2,
      CSR_POOL_MODE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_MAX = 1'b0,
      MODE_AVG = 1'b1
   } pool_mode_type;

   // one lane of the restoring index divider
   typedef struct packed {
      logic [WIN_W-1:0] rem;
      logic [POS_W-1:0] quo;
   } div6_type;

   typedef struct packed {
      logic [POS_W-1:0] r0;
      logic [POS_W-1:0] c0;
      logic [POS_W-1:0] lim;
   } div_args_type;

   typedef struct packed {
      logic [POS_W-1:0] qr;
      logic [POS_W-1:0] qc;
      logic [POS_W-1:0] ql;
      logic             on_grid;
   } div_res_type;

   typedef struct packed {
      logic [POS_W-1:0] r0;
      logic [POS_W-1:0] c0;
      logic [WIN_W-1:0] win;
      logic [SQ_W-1:0]  wsq;
      pool_mode_type    mode;
   } red_cmd_type;

   function automatic div6_type div6_step(input div6_type st, input logic [WIN_W-1:0] dvs);
      logic [WIN_W:0] sh;
      div6_type       nx;
      sh = {st.rem, st.quo[POS_W-1]};
      if (sh >= {1'b0, dvs}) begin
         nx.rem = WIN_W'(sh - {1'b0, dvs});
         nx.quo = {st.quo[POS_W-2:0], 1'b1};
      end else begin
         nx.rem = sh[WIN_W-1:0];
         nx.quo = {st.quo[POS_W-2:0], 1'b0};
      end
      return nx;
   endfunction

endpackage

FILE: design/pl2d_if.sv
// Valid/ready channel interfaces for pixels in and pooled results out
interface pl2d_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [pl2d_pkg::PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface pl2d_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [pl2d_pkg::PIX_W-1:0] pooled_value;
   logic [pl2d_pkg::POS_W-1:0]      out_row;
   logic [pl2d_pkg::POS_W-1:0]      out_col;
   logic                            image_last;

   modport source (output valid, output pooled_value, output out_row, output out_col,
                   output image_last, input ready);
   modport sink (input valid, input pooled_value, input out_row, input out_col,
                 input image_last, output ready);
endinterface

FILE: design/pooling_2d_max_avg.sv
// Pooling block top: config, position tracking, line store, control
// A non-fitting pixel is only stored; a fitting pixel also starts the 6-step stride index divide.
// An on-grid window then takes window_size^2 line-store reads (one read port), a serial
// divide in average mode, and a load of the output register (which waits while it is full).
// Default is 3x3 max pooling. Sync reset restores config defaults and position 0,0;
// line store contents are not cleared.
`include "pooling_2d_max_avg_defines.svh"

module pooling_2d_max_avg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pl2d_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pl2d_pkg::CSR_DATA_W-1:0]     csr_wdata,
   pl2d_req_if.sink                            req_ch,
   pl2d_rsp_if.source                          rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_RED  = 4'b0100,
      S_OUT  = 4'b1000
   } top_state_type;

   localparam int SIDE_W = pl2d_pkg::SIDE_W;
   localparam int WIN_W  = pl2d_pkg::WIN_W;
   localparam int POS_W  = pl2d_pkg::POS_W;
   localparam int PIX_W  = pl2d_pkg::PIX_W;

   top_state_type            state_ff, state_in;
   logic [SIDE_W-1:0]        side_ff, side_in;
   logic [WIN_W-1:0]         win_ff, win_in, stride_ff, stride_in;
   pl2d_pkg::pool_mode_type  mode_ff, mode_in;
   logic [POS_W-1:0]         row_ff, row_in, col_ff, col_in;
   pl2d_pkg::red_cmd_type    cmd_ff, cmd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]  res_ff, res_in;
   logic signed [PIX_W-1:0]  pooled_ff, pooled_in;
   logic [POS_W-1:0]         orow_ff, orow_in, ocol_ff, ocol_in;
   logic                     last_ff, last_in;

   logic [SIDE_W-1:0]        side_eff, win_ext, r_p1, c_p1;
   logic [WIN_W-1:0]         win_eff, stride_eff;
   logic                     wrap, fits, accept;
   logic [POS_W-1:0]         r_cur, c_cur;
   pl2d_pkg::div_args_type   dargs;
   logic                     div_done, red_start, red_done;
   pl2d_pkg::div_res_type    dres;
   logic                     rd_en;
   logic [pl2d_pkg::ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]         rd_data;
   logic signed [PIX_W-1:0]  red_value;

   always_comb begin
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_ff > SIDE_W'(pl2d_pkg::MAX_SIDE)) begin
         side_eff = SIDE_W'(pl2d_pkg::MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(pl2d_pkg::MAX_WINDOW)) begin
         win_eff = WIN_W'(pl2d_pkg::MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
      stride_eff = (stride_ff == '0) ? WIN_W'(1) : stride_ff;
   end

   assign win_ext = SIDE_W'(win_eff);
   assign wrap    = ({1'b0, row_ff} >= side_eff) || ({1'b0, col_ff} >= side_eff);
   assign r_cur   = wrap ? '0 : row_ff;
   assign c_cur   = wrap ? '0 : col_ff;
   assign r_p1    = {1'b0, r_cur} + 1'b1;
   assign c_p1    = {1'b0, c_cur} + 1'b1;
   assign fits    = (win_ext <= side_eff) && (r_p1 >= win_ext) && (c_p1 >= win_ext);
   assign accept  = req_ch.valid && req_ch.ready;

   assign dargs.r0  = POS_W'(r_p1 - win_ext);
   assign dargs.c0  = POS_W'(c_p1 - win_ext);
   assign dargs.lim = POS_W'(side_eff - win_ext);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign red_start    = (state_ff == S_DIV) && div_done && dres.on_grid;

   always_comb begin
      side_in      = side_ff;
      win_in       = win_ff;
      stride_in    = stride_ff;
      mode_in      = mode_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cmd_in       = cmd_ff;
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pooled_in    = pooled_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      last_in      = last_ff;

      if (csr_we) begin
         unique case (csr_index)
            pl2d_pkg::CSR_IMAGE_SIDE:  side_in   = csr_wdata;
            pl2d_pkg::CSR_WINDOW_SIZE: win_in    = csr_wdata[WIN_W-1:0];
            pl2d_pkg::CSR_STRIDE_STEP: stride_in = csr_wdata[WIN_W-1:0];
            pl2d_pkg::CSR_POOL_MODE:   mode_in   = pl2d_pkg::pool_mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end

      if (accept) begin
         if (c_p1 >= side_eff) begin
            col_in = '0;
            row_in = (r_p1 >= side_eff) ? '0 : r_p1[POS_W-1:0];
         end else begin
            col_in = c_p1[POS_W-1:0];
            row_in = r_cur;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && fits) begin
               cmd_in.r0   = dargs.r0;
               cmd_in.c0   = dargs.c0;
               cmd_in.win  = win_eff;
               cmd_in.wsq  = pl2d_pkg::SQ_W'(win_eff) * pl2d_pkg::SQ_W'(win_eff);
               cmd_in.mode = mode_ff;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = dres.on_grid ? S_RED : S_IDLE;
            end
         end
         S_RED: begin
            if (red_done) begin
               res_in   = red_value;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               pooled_in    = res_ff;
               orow_in      = dres.qr;
               ocol_in      = dres.qc;
               last_in      = (dres.qr == dres.ql) && (dres.qc == dres.ql);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= SIDE_W'(5);
         win_ff       <= WIN_W'(3);
         stride_ff    <= WIN_W'(1);
         mode_ff      <= pl2d_pkg::MODE_MAX;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         win_ff       <= win_in;
         stride_ff    <= stride_in;
         mode_ff      <= mode_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      res_ff    <= res_in;
      pooled_ff <= pooled_in;
      orow_ff   <= orow_in;
      ocol_ff   <= ocol_in;
      last_ff   <= last_in;
   end

   pl2d_ram #(
      .WIDTH (PIX_W),
      .DEPTH (pl2d_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (accept),
      .waddr ({r_cur[pl2d_pkg::ROWSEL_W-1:0], c_cur}),
      .wdata (req_ch.pixel_value),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   pl2d_posdiv u_posdiv (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && fits),
      .divisor (stride_eff),
      .args    (dargs),
      .done    (div_done),
      .res     (dres)
   );

   pl2d_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .cmd     (cmd_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (red_done),
      .value   (red_value)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pooled_value = pooled_ff;
   assign rsp_ch.out_row      = orow_ff;
   assign rsp_ch.out_col      = ocol_ff;
   assign rsp_ch.image_last   = last_ff;

   `PL2D_ASSERT_NOW(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV, "index divide finished outside divide state")
   `PL2D_ASSERT_NOW(a_red_done_in_red, clock, reset, red_done, state_ff == S_RED, "window reduce finished outside reduce state")
   `PL2D_ASSERT_NEXT(a_out_holds, clock, reset, (state_ff == S_OUT) && rsp_valid_ff && !rsp_ch.ready, state_ff == S_OUT, "pending result dropped while output busy")
   `PL2D_ASSERT_NOW(a_no_read_idle, clock, reset, rd_en, state_ff == S_RED, "line store read outside reduce state")

endmodule

FILE: design/pl2d_ram.sv
// Generic simple dual-port RAM with registered read
module pl2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/pl2d_posdiv.sv
// Three-lane restoring divider for window origin and last-origin indexes
module pl2d_posdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pl2d_pkg::WIN_W-1:0]    divisor,
   input  pl2d_pkg::div_args_type        args,
   output logic                          done,
   output pl2d_pkg::div_res_type         res
);

   pl2d_pkg::div6_type lr_ff, lc_ff, ll_ff, lr_in, lc_in, ll_in;
   logic [pl2d_pkg::WIN_W-1:0]     dvs_ff, dvs_in;
   logic [pl2d_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   always_comb begin
      lr_in   = lr_ff;
      lc_in   = lc_ff;
      ll_in   = ll_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         lr_in   = '{rem: '0, quo: args.r0};
         lc_in   = '{rem: '0, quo: args.c0};
         ll_in   = '{rem: '0, quo: args.lim};
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         lr_in  = pl2d_pkg::div6_step(lr_ff, dvs_ff);
         lc_in  = pl2d_pkg::div6_step(lc_ff, dvs_ff);
         ll_in  = pl2d_pkg::div6_step(ll_ff, dvs_ff);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pl2d_pkg::DIV_CNT_W'(pl2d_pkg::POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      lr_ff  <= lr_in;
      lc_ff  <= lc_in;
      ll_ff  <= ll_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done        = done_ff;
   assign res.qr      = lr_ff.quo;
   assign res.qc      = lc_ff.quo;
   assign res.ql      = ll_ff.quo;
   assign res.on_grid = (lr_ff.rem == '0) && (lc_ff.rem == '0);

endmodule

FILE: design/pl2d_reduce.sv
// Window read sequencer with max/sum reduction and serial averaging divider
module pl2d_reduce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  pl2d_pkg::red_cmd_type             cmd,
   output logic                              rd_en,
   output logic [pl2d_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [pl2d_pkg::PIX_W-1:0]        rd_data,
   output logic                              done,
   output logic signed [pl2d_pkg::PIX_W-1:0] value
);

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_READ = 3'b010,
      R_DIV  = 3'b100
   } red_state_type;

   localparam int ACC_W = pl2d_pkg::ACC_W;
   localparam int PIX_W = pl2d_pkg::PIX_W;
   localparam int SQ_W  = pl2d_pkg::SQ_W;

   red_state_type                       state_ff, state_in;
   pl2d_pkg::red_cmd_type               cmd_ff, cmd_in;
   logic [pl2d_pkg::ROWSEL_W-1:0]       i_ff, i_in, j_ff, j_in;
   logic                                iss_done_ff, iss_done_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic                                rd_first_ff, rd_first_in;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic [ACC_W-1:0]                    dq_ff, dq_in;
   logic [SQ_W-1:0]                     rem_ff, rem_in;
   logic [pl2d_pkg::AVG_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                neg_ff, neg_in;
   logic                                done_ff, done_in;
   logic signed [PIX_W-1:0]             value_ff, value_in;
   logic [pl2d_pkg::ROWSEL_W-1:0]       wm1;
   logic signed [ACC_W-1:0]             pix;
   logic [SQ_W:0]                       sh;
   logic [ACC_W-1:0]                    dq_step;

   assign wm1 = pl2d_pkg::ROWSEL_W'(cmd_ff.win - 1'b1);
   assign pix = ACC_W'($signed(rd_data));
   assign sh  = {rem_ff, dq_ff[ACC_W-1]};

   assign rd_en   = (state_ff == R_READ) && !iss_done_ff;
   assign rd_addr = {pl2d_pkg::ROWSEL_W'(cmd_ff.r0[pl2d_pkg::ROWSEL_W-1:0] + i_ff),
                     pl2d_pkg::POS_W'(cmd_ff.c0 + {3'b0, j_ff})};

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      iss_done_in = iss_done_ff;
      rd_vld_in   = rd_en;
      rd_first_in = rd_en && (i_ff == '0) && (j_ff == '0);
      acc_in      = acc_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      done_in     = 1'b0;
      value_in    = value_ff;
      dq_step     = {dq_ff[ACC_W-2:0], 1'b0};
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               cmd_in      = cmd;
               i_in        = '0;
               j_in        = '0;
               iss_done_in = 1'b0;
               state_in    = R_READ;
            end
         end
         R_READ: begin
            if (!iss_done_ff) begin
               if (j_ff == wm1) begin
                  j_in = '0;
                  if (i_ff == wm1) begin
                     iss_done_in = 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (rd_first_ff) begin
                  acc_in = pix;
               end else if (cmd_ff.mode == pl2d_pkg::MODE_AVG) begin
                  acc_in = acc_ff + pix;
               end else if (pix > acc_ff) begin
                  acc_in = pix;
               end
            end
            if (iss_done_ff && !rd_vld_ff) begin
               if (cmd_ff.mode == pl2d_pkg::MODE_AVG) begin
                  neg_in   = acc_ff[ACC_W-1];
                  dq_in    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = R_DIV;
               end else begin
                  value_in = acc_ff[PIX_W-1:0];
                  done_in  = 1'b1;
                  state_in = R_IDLE;
               end
            end
         end
         R_DIV: begin
            if (sh >= {1'b0, cmd_ff.wsq}) begin
               rem_in  = SQ_W'(sh - {1'b0, cmd_ff.wsq});
               dq_step = {dq_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = sh[SQ_W-1:0];
            end
            dq_in  = dq_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pl2d_pkg::AVG_CNT_W'(ACC_W - 1)) begin
               value_in = neg_ff ? PIX_W'(-dq_step[PIX_W-1:0]) : dq_step[PIX_W-1:0];
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= R_IDLE;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
      end
      cmd_ff      <= cmd_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      iss_done_ff <= iss_done_in;
      rd_first_ff <= rd_first_in;
      acc_ff      <= acc_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      value_ff    <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule
